// ----- rtl/core/mma_pkg.sv -----
`default_nettype none

package mma_pkg;

    // datapath word width, default
    localparam int DEFAULT_WORD_BITS = 64;

    // pipeline depth from input register to output register
    localparam int PIPE_STAGES = 9;

    // beat field widths
    localparam int OPCODE_W   = 3;
    localparam int OPERAND_A_W = 64;
    localparam int OPERAND_B_W = 63;
    localparam int VALUE_W    = 63;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 64;

    // configuration registers
    localparam int MODULUS_W   = 62;
    localparam int NEG_INV_W   = 64;
    localparam int R_SQUARED_W = 62;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODULUS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEG_INV   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_R_SQUARED = 2'd2;

    localparam logic [MODULUS_W-1:0]   MODULUS_RST   = 62'd1;
    localparam logic [NEG_INV_W-1:0]   NEG_INV_RST   = '1;
    localparam logic [R_SQUARED_W-1:0] R_SQUARED_RST = '0;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TO_MONT   = 3'd0,
        OP_FROM_MONT = 3'd1,
        OP_ADD       = 3'd2,
        OP_SUB       = 3'd3,
        OP_MUL       = 3'd4,
        OP_NEG       = 3'd5,
        OP_EQUAL     = 3'd6
    } op_t;

    // stage enables of a two-stage wide multiplier
    typedef struct packed {
        logic part;
        logic sum;
    } mul_en_t;

endpackage

`default_nettype wire

// ----- rtl/core/mma_wide_mul.sv -----
`default_nettype none

module mma_wide_mul
    import mma_pkg::*;
#(
    parameter int WORD_BITS = DEFAULT_WORD_BITS
)
(
    input  wire logic                     clk,
    input  wire mul_en_t                  en,
    input  wire logic [WORD_BITS-1:0]     x,
    input  wire logic [WORD_BITS-1:0]     y,
    output logic      [2*WORD_BITS-1:0]   prod
);

    localparam int W  = WORD_BITS;
    localparam int H  = (W + 1) / 2;
    localparam int L  = W - H;
    localparam int DW = 2 * W;

    // half-word partial products
    logic [2*H-1:0] p00_reg;
    logic [H+L-1:0] p01_reg;
    logic [L+H-1:0] p10_reg;
    logic [2*L-1:0] p11_reg;
    logic [DW-1:0]  prod_reg;
    logic [DW-1:0]  prod_next;

    always_ff @(posedge clk)
    begin
        if (en.part)
        begin
            p00_reg <= x[H-1:0] * y[H-1:0];
            p01_reg <= x[H-1:0] * y[W-1:H];
            p10_reg <= x[W-1:H] * y[H-1:0];
            p11_reg <= x[W-1:H] * y[W-1:H];
        end
    end

    always_comb
    begin
        prod_next = DW'(p00_reg)
                  + (DW'(p01_reg) << H)
                  + (DW'(p10_reg) << H)
                  + (DW'(p11_reg) << (2 * H));
    end

    always_ff @(posedge clk)
    begin
        if (en.sum)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/core/montgomery_modular_alu_core.sv -----
// Montgomery modular ALU: one operation per beat on residues kept lazily in [0, 2N).
// Opcodes on s_axis_tuser: to_mont, from_mont, add, sub, mul, neg, equal; every input
// beat gives exactly one output beat, in order. The core is a 9-stage pipeline that
// accepts one beat every clock while the output side does not stall. The stages follow
// the REDC chain: the operand product (two stages), the quotient m = lo * neg_inverse
// (two stages) and m * N (two stages), each multiplier split into half-word partial
// products, then the double-width add and the final conditional subtract. Add, sub, neg
// and equal run alongside and ride the same pipeline. Each stage holds while the next one
// is full and not moving, so a stall loses or repeats nothing and bubbles are squeezed
// out. Write modulus, neg_inverse and r_squared through the cfg port only while the core
// is empty.
`default_nettype none

module montgomery_modular_alu_core
    import mma_pkg::*;
#(
    parameter int WORD_BITS = DEFAULT_WORD_BITS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    // configuration write port
    input  wire logic                    cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,

    // input beats
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]    s_axis_tdata,   // operand_a[63:0], operand_b[126:64]
    input  wire logic [OPCODE_W-1:0]     s_axis_tuser,   // opcode[2:0]

    // output beats
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [OUT_DATA_W-1:0]        m_axis_tdata    // value[62:0], is_equal[63]
);

    localparam int W  = WORD_BITS;
    localparam int H  = (W + 1) / 2;
    localparam int L  = W - H;
    localparam int DW = 2 * W;
    localparam int NS = PIPE_STAGES;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [MODULUS_W-1:0]   modulus_reg;
    logic [NEG_INV_W-1:0]   neg_inverse_reg;
    logic [R_SQUARED_W-1:0] r_squared_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg     <= MODULUS_RST;
            neg_inverse_reg <= NEG_INV_RST;
            r_squared_reg   <= R_SQUARED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODULUS:   modulus_reg     <= cfg_data[MODULUS_W-1:0];
                CFG_NEG_INV:   neg_inverse_reg <= cfg_data[NEG_INV_W-1:0];
                CFG_R_SQUARED: r_squared_reg   <= cfg_data[R_SQUARED_W-1:0];
                default:       ;
            endcase
        end
    end

    // registers seen at word width; 2N wraps at the word width
    logic [W-1:0] n_w;
    logic [W-1:0] n2_w;
    logic [W-1:0] ni_w;
    logic [W-1:0] rsq_w;

    assign n_w   = W'(modulus_reg);
    assign n2_w  = W'({modulus_reg, 1'b0});
    assign ni_w  = W'(neg_inverse_reg);
    assign rsq_w = W'(r_squared_reg);

    // ---------------------------------------------------------------
    // stage valids and per-stage advance
    // ---------------------------------------------------------------
    logic [NS:1]   valid_reg;
    logic [NS:1]   valid_next;
    logic [NS+1:1] en;

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        en[NS+1] = m_axis_tready;
        for (int k = NS; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        valid_next[1] = en[1] ? s_axis_tvalid : valid_reg[1];
        for (int k = 2; k <= NS; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = en[1];

    // ---------------------------------------------------------------
    // stage 1: input register, multiplier operand select, raw add/sub/neg
    // ---------------------------------------------------------------
    op_t          in_op;
    logic [W-1:0] in_a;
    logic [W-1:0] in_b;
    logic [W-1:0] y1_next;
    logic [W-1:0] pre1_next;

    assign in_op = op_t'(s_axis_tuser);
    assign in_a  = W'(s_axis_tdata[OPERAND_A_W-1:0]);
    assign in_b  = W'(s_axis_tdata[OPERAND_A_W+OPERAND_B_W-1:OPERAND_A_W]);

    // from_mont multiplies by one so REDC sees hi = 0, lo = a
    always_comb
    begin
        case (in_op)
            OP_TO_MONT:   y1_next = rsq_w;
            OP_FROM_MONT: y1_next = W'(1);
            OP_MUL:       y1_next = in_b;
            default:      y1_next = '0;
        endcase
    end

    always_comb
    begin
        case (in_op)
            OP_ADD:  pre1_next = in_a + in_b;
            OP_SUB:  pre1_next = in_a - in_b + n2_w;
            OP_NEG:  pre1_next = (in_a != '0) ? n2_w - in_a : '0;
            default: pre1_next = '0;
        endcase
    end

    op_t          op1_reg;
    logic [W-1:0] a1_reg;
    logic [W-1:0] b1_reg;
    logic [W-1:0] y1_reg;
    logic [W-1:0] pre1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            op1_reg  <= in_op;
            a1_reg   <= in_a;
            b1_reg   <= in_b;
            y1_reg   <= y1_next;
            pre1_reg <= pre1_next;
        end
    end

    // ---------------------------------------------------------------
    // stages 2-3: operand product a * y
    // ---------------------------------------------------------------
    mul_en_t       mul_ay_en;
    logic [DW-1:0] prod3;

    // fields from the top: part, sum
    assign mul_ay_en = {en[2], en[3]};

    mma_wide_mul #(
        .WORD_BITS (WORD_BITS)
    ) u_mul_ay (
        .clk  (clk),
        .en   (mul_ay_en),
        .x    (a1_reg),
        .y    (y1_reg),
        .prod (prod3)
    );

    // stage 2 side path: lazy reduction of add/sub, reduce both equal operands
    logic [W-1:0] simp2_next;
    logic [W-1:0] ra2_next;
    logic [W-1:0] rb2_next;

    always_comb
    begin
        case (op1_reg) inside
            OP_ADD, OP_SUB: simp2_next = (pre1_reg >= n2_w) ? pre1_reg - n2_w : pre1_reg;
            OP_NEG:         simp2_next = pre1_reg;
            default:        simp2_next = '0;
        endcase
    end

    assign ra2_next = (a1_reg >= n_w) ? a1_reg - n_w : a1_reg;
    assign rb2_next = (b1_reg >= n_w) ? b1_reg - n_w : b1_reg;

    op_t          op2_reg;
    logic [W-1:0] simp2_reg;
    logic [W-1:0] ra2_reg;
    logic [W-1:0] rb2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            op2_reg   <= op1_reg;
            simp2_reg <= simp2_next;
            ra2_reg   <= ra2_next;
            rb2_reg   <= rb2_next;
        end
    end

    // stage 3 side path: equality and result routing flags
    logic eq3_next;
    logic redc3_next;
    logic reds3_next;

    assign eq3_next   = (op2_reg == OP_EQUAL) && (ra2_reg == rb2_reg);
    assign redc3_next = op2_reg inside {OP_TO_MONT, OP_FROM_MONT, OP_MUL};
    assign reds3_next = (op2_reg == OP_FROM_MONT);

    // side results ride along until the output stage
    logic [W-1:0] simp_c_reg [3:8];
    logic         eq_c_reg   [3:8];
    logic         redc_c_reg [3:8];
    logic         reds_c_reg [3:8];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            simp_c_reg[3] <= simp2_reg;
            eq_c_reg[3]   <= eq3_next;
            redc_c_reg[3] <= redc3_next;
            reds_c_reg[3] <= reds3_next;
        end
        for (int k = 4; k <= 8; k++)
        begin
            if (en[k])
            begin
                simp_c_reg[k] <= simp_c_reg[k-1];
                eq_c_reg[k]   <= eq_c_reg[k-1];
                redc_c_reg[k] <= redc_c_reg[k-1];
                reds_c_reg[k] <= reds_c_reg[k-1];
            end
        end
    end

    // the operand product is held until the final REDC add
    logic [DW-1:0] prod_c_reg [4:7];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            prod_c_reg[4] <= prod3;
        end
        for (int k = 5; k <= 7; k++)
        begin
            if (en[k])
            begin
                prod_c_reg[k] <= prod_c_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // stages 4-5: m = lo * neg_inverse mod 2^W, low half only
    // ---------------------------------------------------------------
    logic [W-1:0]   lo3;
    logic [2*H-1:0] q00_reg;
    logic [H+L-1:0] q01_reg;
    logic [L+H-1:0] q10_reg;

    assign lo3 = prod3[W-1:0];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            q00_reg <= lo3[H-1:0] * ni_w[H-1:0];
            q01_reg <= lo3[H-1:0] * ni_w[W-1:H];
            q10_reg <= lo3[W-1:H] * ni_w[H-1:0];
        end
    end

    logic [W-1:0] m5_reg;
    logic [W-1:0] m5_next;

    // cross terms land at bit H; anything above the word drops out
    assign m5_next = W'(q00_reg) + (W'(q01_reg + q10_reg) << H);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            m5_reg <= m5_next;
        end
    end

    // ---------------------------------------------------------------
    // stages 6-7: m * N
    // ---------------------------------------------------------------
    mul_en_t       mul_mn_en;
    logic [DW-1:0] mn7;

    // fields from the top: part, sum
    assign mul_mn_en = {en[6], en[7]};

    mma_wide_mul #(
        .WORD_BITS (WORD_BITS)
    ) u_mul_mn (
        .clk  (clk),
        .en   (mul_mn_en),
        .x    (m5_reg),
        .y    (n_w),
        .prod (mn7)
    );

    // ---------------------------------------------------------------
    // stage 8: (product + m * N) / 2^W, sum wraps at double width
    // ---------------------------------------------------------------
    logic [DW-1:0] sum8;
    logic [W-1:0]  r8_reg;

    assign sum8 = prod_c_reg[7] + mn7;

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            r8_reg <= sum8[DW-1:W];
        end
    end

    // ---------------------------------------------------------------
    // stage 9: final reduce for from_mont, result select, output register
    // ---------------------------------------------------------------
    logic [W-1:0] value9_next;
    logic [W-1:0] value9_reg;
    logic         eq9_reg;

    always_comb
    begin
        if (!redc_c_reg[8])
        begin
            value9_next = simp_c_reg[8];
        end
        else if (reds_c_reg[8] && (r8_reg >= n_w))
        begin
            value9_next = r8_reg - n_w;
        end
        else
        begin
            value9_next = r8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            value9_reg <= value9_next;
            eq9_reg    <= eq_c_reg[8];
        end
    end

    assign m_axis_tvalid = valid_reg[NS];
    assign m_axis_tdata  = {eq9_reg, VALUE_W'(value9_reg)};

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // a ready sink lets every stage move, so input is always taken
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output side is ready");

    // an empty output stage must open the input
    a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[NS] |-> s_axis_tready)
        else $error("input stalled with an empty output stage");

    // equality results carry a zero value
    a_equal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[VALUE_W]) |-> (m_axis_tdata[VALUE_W-1:0] == '0))
        else $error("equal flag set with nonzero value");

    // a held first stage keeps its beat
    a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[1] && !en[2]) |=> (valid_reg[1] && $stable(op1_reg) && $stable(a1_reg)))
        else $error("stalled first stage lost its beat");

endmodule

`default_nettype wire
